### src/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by every other file of the block.
`default_nettype none

package ffha_pkg;

  localparam int MaxSegments = 64;
  localparam int HeaderBytes = 16;
  localparam int HeapLimit   = 16777216;

  localparam int AddrW  = 32;
  localparam int ReqW   = 25;
  localparam int HsizeW = 25;
  localparam int SegW   = 25;
  localparam int NeedW  = 26;

  localparam logic [AddrW-1:0]  ResetHeapBase = '0;
  localparam logic [HsizeW-1:0] ResetHeapSize = HsizeW'(1048576);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e              operation;
    logic [ReqW-1:0]  request_size;
    logic [AddrW-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] granted_address;
  } out_item_t;

  typedef struct packed {
    logic [SegW-1:0] start;
    logic [SegW-1:0] size;
    logic            used;
  } seg_t;

  typedef enum logic [2:0] {
    P_HOLD   = 3'd0,
    P_ZERO   = 3'd1,
    P_INC    = 3'd2,
    P_DEC    = 3'd3,
    P_CNT_M1 = 3'd4,
    P_HIT_M1 = 3'd5,
    P_HIT_P1 = 3'd6
  } ptr_op_e;

  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_INIT     = 3'd1,
    WR_UP       = 3'd2,
    WR_DOWN     = 3'd3,
    WR_SPLIT_LO = 3'd4,
    WR_SPLIT_HI = 3'd5,
    WR_CUR      = 3'd6,
    WR_PREV     = 3'd7
  } wr_op_e;

  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_ONE  = 2'd1,
    C_INC  = 2'd2,
    C_DEC  = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD  = 2'd0,
    CUR_LOAD  = 2'd1,
    CUR_MERGE = 2'd2
  } cur_op_e;

  typedef struct packed {
    logic    in_load;
    ptr_op_e ptr_op;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    cur_op_e cur_op;
    logic    hit_load;
    logic    res_load;
    status_e res_status;
    logic    res_grant;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic fit;
    logic match;
    logic at_cnt;
    logic at_hit;
    logic full;
    logic null_addr;
    logic rd_used;
    logic hit_zero;
  } sts_t;

endpackage

`default_nettype wire

### src/ffha_dpath.sv
// Datapath of the allocator: segment table memory, pointers, count and result registers.
// Depends on ffha_pkg; driven by ffha_ctrl through ctl_t.
`default_nettype none

module ffha_dpath import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = MaxSegments
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire cfg_reg_e         cfg_index_i,
  input  wire logic [AddrW-1:0] cfg_data_i,
  input  wire in_item_t         in_data_i,
  output out_item_t             out_data_o,
  input  wire ctl_t             ctl_i,
  output sts_t                  sts_o
);

  localparam int CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam logic [SegW-1:0]   Hdr     = SegW'(HeaderBytes);
  localparam logic [SegW-1:0]   Hdr2    = SegW'(2 * HeaderBytes);
  localparam logic [HsizeW-1:0] Hdr3    = HsizeW'(3 * HeaderBytes);
  localparam logic [HsizeW-1:0] HsLimit = HsizeW'(HeapLimit);

  logic [AddrW-1:0]  base_q;
  logic [HsizeW-1:0] hsize_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   hit_q;
  seg_t              cur_q, rd_q;
  logic [ReqW-1:0]   req_q;
  logic [NeedW-1:0]  need_q;
  logic [AddrW-1:0]  addr_q;
  status_e           res_status_q;
  logic [AddrW-1:0]  res_grant_q;
  out_item_t         out_q;

  seg_t mem [MAX_SEGMENTS];

  logic [HsizeW-1:0] hs_clamp;
  seg_t              init_seg;
  logic [CntW-1:0]   ptr_p1, ptr_m1, hit_p1, hit_m1;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  seg_t              wr_data;
  logic [AddrW-1:0]  rd_payload, cur_payload;

  assign hs_clamp       = (hsize_q > HsLimit) ? HsLimit : hsize_q;
  assign init_seg.start = Hdr2;
  assign init_seg.size  = (hs_clamp >= Hdr3) ? SegW'(hs_clamp - Hdr3) : '0;
  assign init_seg.used  = 1'b0;

  assign ptr_p1 = ptr_q + CntW'(1);
  assign ptr_m1 = ptr_q - CntW'(1);
  assign hit_p1 = hit_q + CntW'(1);
  assign hit_m1 = hit_q - CntW'(1);

  assign rd_payload  = base_q + AddrW'(rd_q.start) + AddrW'(HeaderBytes);
  assign cur_payload = base_q + AddrW'(cur_q.start) + AddrW'(HeaderBytes);

  always_comb begin
    case (ctl_i.ptr_op)
      P_HOLD:   ptr_d = ptr_q;
      P_ZERO:   ptr_d = '0;
      P_INC:    ptr_d = ptr_p1;
      P_DEC:    ptr_d = ptr_m1;
      P_CNT_M1: ptr_d = cnt_q - CntW'(1);
      P_HIT_M1: ptr_d = hit_m1;
      P_HIT_P1: ptr_d = hit_p1;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (ctl_i.cnt_op)
      C_HOLD:  cnt_d = cnt_q;
      C_ONE:   cnt_d = CntW'(1);
      C_INC:   cnt_d = cnt_q + CntW'(1);
      C_DEC:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = rd_q;
    case (ctl_i.wr_op)
      WR_NONE: wr_en = 1'b0;
      WR_INIT: wr_data = init_seg;
      WR_UP:   wr_addr = ptr_p1[IdxW-1:0];
      WR_DOWN: wr_addr = ptr_m1[IdxW-1:0];
      WR_SPLIT_LO: begin
        wr_addr       = hit_q[IdxW-1:0];
        wr_data.start = cur_q.start;
        wr_data.size  = SegW'(req_q);
        wr_data.used  = 1'b1;
      end
      WR_SPLIT_HI: begin
        wr_addr       = hit_p1[IdxW-1:0];
        wr_data.start = SegW'(cur_q.start + need_q);
        wr_data.size  = SegW'(cur_q.size - need_q);
        wr_data.used  = 1'b0;
      end
      WR_CUR: begin
        wr_addr = hit_q[IdxW-1:0];
        wr_data = cur_q;
      end
      WR_PREV: begin
        wr_addr       = hit_m1[IdxW-1:0];
        wr_data.start = rd_q.start;
        wr_data.size  = rd_q.size + Hdr + cur_q.size;
        wr_data.used  = 1'b0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // read address follows the next pointer, so rd_q holds mem[ptr_q] unless that entry was written in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= ResetHeapBase;
      hsize_q <= ResetHeapSize;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HEAP_BASE: base_q  <= cfg_data_i;
          REG_HEAP_SIZE: hsize_q <= cfg_data_i[HsizeW-1:0];
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_load) begin
      req_q  <= in_data_i.request_size;
      need_q <= NeedW'(in_data_i.request_size) + NeedW'(HeaderBytes);
      addr_q <= in_data_i.release_address;
    end
    if (ctl_i.hit_load) begin
      hit_q <= ptr_q;
    end
    case (ctl_i.cur_op)
      CUR_LOAD: begin
        cur_q.start <= rd_q.start;
        cur_q.size  <= rd_q.size;
        cur_q.used  <= 1'b0;
      end
      CUR_MERGE: cur_q.size <= cur_q.size + Hdr + rd_q.size;
      default: ;
    endcase
    if (ctl_i.res_load) begin
      res_status_q <= ctl_i.res_status;
      res_grant_q  <= ctl_i.res_grant ? cur_payload : '0;
    end
    if (ctl_i.out_load) begin
      out_q.status          <= res_status_q;
      out_q.granted_address <= res_grant_q;
    end
  end

  // a free segment fits when its payload holds the request plus one header
  assign sts_o.fit       = !rd_q.used && ({1'b0, rd_q.size} >= need_q);
  assign sts_o.match     = rd_q.used && (rd_payload == addr_q);
  assign sts_o.at_cnt    = (ptr_q == cnt_q);
  assign sts_o.at_hit    = (ptr_q == hit_q);
  assign sts_o.full      = (cnt_q >= CntW'(MAX_SEGMENTS));
  assign sts_o.null_addr = (addr_q == '0);
  assign sts_o.rd_used   = rd_q.used;
  assign sts_o.hit_zero  = (hit_q == '0);

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### src/ffha_ctrl.sv
// Controller of the allocator: sequences scans, shifts, splits and merges.
// Depends on ffha_pkg; commands ffha_dpath through ctl_t, reads sts_t.
`default_nettype none

module ffha_ctrl import ffha_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic in_valid_i,
  input  wire op_e  in_op_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output ctl_t      ctl_o,
  input  wire sts_t sts_i
);

  typedef enum logic [11:0] {
    S_INIT      = 12'b0000_0000_0001,
    S_IDLE      = 12'b0000_0000_0010,
    S_ASCAN     = 12'b0000_0000_0100,
    S_AUP       = 12'b0000_0000_1000,
    S_ASPLIT_HI = 12'b0000_0001_0000,
    S_ASPLIT_LO = 12'b0000_0010_0000,
    S_FSCAN     = 12'b0000_0100_0000,
    S_FNEXT     = 12'b0000_1000_0000,
    S_RMVN      = 12'b0001_0000_0000,
    S_FPREV     = 12'b0010_0000_0000,
    S_RMVC      = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o       = '0;
    case (state_q)
      S_INIT: begin
        ctl_o.wr_op  = WR_INIT;
        ctl_o.cnt_op = C_ONE;
        state_d      = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.in_load = 1'b1;
          ctl_o.ptr_op  = P_ZERO;
          state_d       = (in_op_i == OP_FREE) ? S_FSCAN : S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (sts_i.at_cnt) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_NO_FIT;
          state_d          = S_DONE;
        end else if (sts_i.fit) begin
          ctl_o.hit_load = 1'b1;
          ctl_o.cur_op   = CUR_LOAD;
          if (sts_i.full) begin
            ctl_o.res_load   = 1'b1;
            ctl_o.res_status = ST_FULL;
            state_d          = S_DONE;
          end else begin
            ctl_o.ptr_op = P_CNT_M1;
            state_d      = S_AUP;
          end
        end else begin
          ctl_o.ptr_op = P_INC;
        end
      end
      S_AUP: begin
        // open a gap after the hit, moving the tail up one entry
        if (sts_i.at_hit) begin
          state_d = S_ASPLIT_HI;
        end else begin
          ctl_o.wr_op  = WR_UP;
          ctl_o.ptr_op = P_DEC;
        end
      end
      S_ASPLIT_HI: begin
        ctl_o.wr_op = WR_SPLIT_HI;
        state_d     = S_ASPLIT_LO;
      end
      S_ASPLIT_LO: begin
        ctl_o.wr_op      = WR_SPLIT_LO;
        ctl_o.cnt_op     = C_INC;
        ctl_o.res_load   = 1'b1;
        ctl_o.res_status = ST_OK;
        ctl_o.res_grant  = 1'b1;
        state_d          = S_DONE;
      end
      S_FSCAN: begin
        if (sts_i.null_addr || sts_i.at_cnt) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_IGNORED;
          state_d          = S_DONE;
        end else if (sts_i.match) begin
          ctl_o.hit_load = 1'b1;
          ctl_o.cur_op   = CUR_LOAD;
          ctl_o.ptr_op   = P_INC;
          state_d        = S_FNEXT;
        end else begin
          ctl_o.ptr_op = P_INC;
        end
      end
      S_FNEXT: begin
        if (sts_i.at_cnt || sts_i.rd_used) begin
          ctl_o.ptr_op = P_HIT_M1;
          state_d      = S_FPREV;
        end else begin
          ctl_o.cur_op = CUR_MERGE;
          ctl_o.ptr_op = P_INC;
          state_d      = S_RMVN;
        end
      end
      S_RMVN: begin
        // drop the entry after the hit
        if (sts_i.at_cnt) begin
          ctl_o.cnt_op = C_DEC;
          ctl_o.ptr_op = P_HIT_M1;
          state_d      = S_FPREV;
        end else begin
          ctl_o.wr_op  = WR_DOWN;
          ctl_o.ptr_op = P_INC;
        end
      end
      S_FPREV: begin
        if (sts_i.hit_zero || sts_i.rd_used) begin
          ctl_o.wr_op      = WR_CUR;
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else begin
          ctl_o.wr_op  = WR_PREV;
          ctl_o.ptr_op = P_HIT_P1;
          state_d      = S_RMVC;
        end
      end
      S_RMVC: begin
        // drop the hit entry: ptr starts at hit+1 and each entry moves down one
        if (sts_i.at_cnt) begin
          ctl_o.cnt_op     = C_DEC;
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else begin
          ctl_o.wr_op  = WR_DOWN;
          ctl_o.ptr_op = P_INC;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
//
//   channel  signals                               transfer when
//   in       in_valid_i in_stall_o in_data_i       valid high, stall low
//   out      out_valid_o out_stall_i out_data_o    valid high, stall low
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i   valid and ready high
//            cfg_data_i
//
// One item at a time. The table is walked one entry per cycle through the
// memory, with one read and one write port. After reset and after every
// configuration write the table is rebuilt, with in_stall_o high. A result
// waits in the output register while out_stall_i is high; the next item may
// be accepted meanwhile.
`default_nettype none

module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = MaxSegments
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire cfg_reg_e         cfg_index_i,
  input  wire logic [AddrW-1:0] cfg_data_i
);

  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  ffha_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### src/ffha_checker.sv
// Port-level checks of the first-fit heap allocator, bound to its top level.
// Depends on ffha_pkg and first_fit_heap_allocator_top.
`default_nettype none

module ffha_checker import ffha_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire out_item_t        out_data_o,
  input wire logic             cfg_valid_i,
  input wire logic             cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.granted_address == '0))
    else $error("address granted with failing status");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is at work");

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("item taken during table rebuild");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);

`default_nettype wire
